>>> rtl/u8dec_pkg.sv
// ---------------------------------------------------------------------------
// u8dec_pkg
// Types, constants and helper functions shared by the UTF-8 decoder modules.
// ---------------------------------------------------------------------------
package u8dec_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0]  LEAD2_LO    = 8'hc2;
   localparam logic [7:0]  LEAD2_HI    = 8'hdf;
   localparam logic [7:0]  LEAD3_LO    = 8'he0;
   localparam logic [7:0]  LEAD3_HI    = 8'hef;
   localparam logic [7:0]  LEAD4_LO    = 8'hf0;
   localparam logic [7:0]  LEAD4_HI    = 8'hf4;
   localparam logic [7:0]  ASCII_HI    = 8'h7f;
   localparam logic [5:0]  CONT_MASK   = 6'h3f;
   localparam logic [20:0] CP_MAX      = 21'h10ffff;
   localparam logic [20:0] BMP_MAX     = 21'h00ffff;
   localparam logic [20:0] SURR_LO     = 21'h00d800;
   localparam logic [20:0] SURR_HI     = 21'h00dfff;
   localparam logic [20:0] MIN_LEN2    = 21'h000080;
   localparam logic [20:0] MIN_LEN3    = 21'h000800;
   localparam logic [20:0] MIN_LEN4    = 21'h010000;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        is_valid;
      logic [2:0]  byte_count;
      logic [1:0]  utf16_units;
      logic        is_whitespace;
      logic        last_of_run;
   } rsp_type;

   // one decoded byte: a run of invalid results, then optionally one valid one
   typedef struct packed {
      logic [2:0]  n_invalid;
      logic        has_valid;
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic [1:0]  utf16_units;
      logic        is_whitespace;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic ecma_space(input logic [20:0] c);
      ecma_space = (c == 21'h09) || (c == 21'h0a) || (c == 21'h0b) || (c == 21'h0c)
                || (c == 21'h0d) || (c == 21'h20) || (c == 21'h00a0) || (c == 21'h1680)
                || ((c >= 21'h2000) && (c <= 21'h200a)) || (c == 21'h2028)
                || (c == 21'h2029) || (c == 21'h202f) || (c == 21'h205f)
                || (c == 21'h3000) || (c == 21'hfeff);
   endfunction

endpackage

>>> rtl/utf8_validating_decoder.sv
// ---------------------------------------------------------------------------
// utf8_validating_decoder
// UTF-8 byte stream to code points, with rejection of malformed sequences.
// ---------------------------------------------------------------------------
// usage:
//   req channel carries one byte per item with an end-of-string mark.
//   rsp channel carries decoded results; a byte gives zero to four of them,
//   the final one of a byte tagged last_of_run. a rejected byte of a bad
//   sequence comes out as one invalid result with code point zero.
//   a tracker takes one byte per cycle while req_stall is low and writes at
//   most one command per byte to a queue of QueueDepth entries; an expander
//   drains it at one result per cycle while rsp_stall is low into an output
//   register. throughput: one byte per cycle while each byte yields at most
//   one result and rsp_stall is low; a byte with more results holds the
//   expander until all are out, and the queue absorbs such bursts.
//   req_stall rises only when the queue is full.
//   rsp_stall holds the output register and, once the queue fills, req.
//   reset clears the open sequence, the queue and the output register.
// ---------------------------------------------------------------------------
module utf8_validating_decoder #(
   parameter int QueueDepth = u8dec_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  u8dec_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output u8dec_pkg::rsp_type rsp_data
);
   import u8dec_pkg::*;

   logic             accept;
   logic             push;
   logic             pop;
   cmd_type          cmd;
   cmd_type          head;
   queue_status_type status;

   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   u8dec_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .cmd      (cmd)
   );

   u8dec_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   u8dec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // no write into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("command written into full queue");

   // no read from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("command taken from empty queue");

   // invalid results carry the fixed error payload
   a_invalid_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_valid) |->
         (rsp_data.code_point == 21'd0 && rsp_data.byte_count == 3'd1 &&
          rsp_data.utf16_units == 2'd1 && !rsp_data.is_whitespace))
      else $error("invalid result with nonzero payload");

   // utf-16 unit count follows the code point
   a_utf16_units: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_valid) |->
         ((rsp_data.utf16_units == 2'd2) == (rsp_data.code_point > BMP_MAX)))
      else $error("utf-16 unit count does not match code point");

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

>>> rtl/u8dec_front.sv
// ---------------------------------------------------------------------------
// u8dec_front
// Sequence tracker: classifies each byte and emits at most one result command.
// ---------------------------------------------------------------------------
module u8dec_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  u8dec_pkg::req_type req_data,
   output logic              push,
   output u8dec_pkg::cmd_type cmd
);
   import u8dec_pkg::*;

   logic [1:0]  pending_ff, pending_in;
   logic [2:0]  exp_len_ff, exp_len_in;
   logic [20:0] partial_ff, partial_in;

   logic [7:0]  b;
   logic        is_cont;
   logic [2:0]  got;
   logic [20:0] v;
   logic [20:0] min_val;
   logic [2:0]  n_inv;
   logic        has_valid;
   logic [20:0] vcp;
   logic [2:0]  vbytes;

   always_comb begin
      b          = req_data.in_byte;
      is_cont    = (b[7:6] == 2'b10);
      got        = {1'b0, pending_ff} + 3'd1;
      v          = {partial_ff[14:0], b[5:0] & CONT_MASK};
      pending_in = pending_ff;
      exp_len_in = exp_len_ff;
      partial_in = partial_ff;
      n_inv      = 3'd0;
      has_valid  = 1'b0;
      vcp        = 21'd0;
      vbytes     = 3'd1;
      unique case (exp_len_ff)
         3'd2:    min_val = MIN_LEN2;
         3'd3:    min_val = MIN_LEN3;
         default: min_val = MIN_LEN4;
      endcase

      if ((pending_ff != 2'd0) && is_cont) begin
         if (got >= exp_len_ff) begin
            if ((v < min_val) || (v > CP_MAX) || ((v >= SURR_LO) && (v <= SURR_HI))) begin
               n_inv = got;
            end else begin
               has_valid = 1'b1;
               vcp       = v;
               vbytes    = got;
            end
            pending_in = 2'd0;
            exp_len_in = 3'd0;
            partial_in = 21'd0;
         end else begin
            pending_in = got[1:0];
            partial_in = v;
         end
      end else begin
         // no open sequence, or a broken one: flush what was collected, then treat byte as lead
         n_inv      = {1'b0, pending_ff};
         pending_in = 2'd0;
         exp_len_in = 3'd0;
         partial_in = 21'd0;
         priority if (b <= ASCII_HI) begin
            has_valid = 1'b1;
            vcp       = {13'd0, b};
         end else if ((b >= LEAD2_LO) && (b <= LEAD2_HI)) begin
            pending_in = 2'd1;
            exp_len_in = 3'd2;
            partial_in = {16'd0, b[4:0]};
         end else if ((b >= LEAD3_LO) && (b <= LEAD3_HI)) begin
            pending_in = 2'd1;
            exp_len_in = 3'd3;
            partial_in = {17'd0, b[3:0]};
         end else if ((b >= LEAD4_LO) && (b <= LEAD4_HI)) begin
            pending_in = 2'd1;
            exp_len_in = 3'd4;
            partial_in = {18'd0, b[2:0]};
         end else begin
            n_inv = n_inv + 3'd1;
         end
      end

      // end of string flushes an open sequence as errors
      if (req_data.end_of_string && (pending_in != 2'd0)) begin
         n_inv      = n_inv + {1'b0, pending_in};
         pending_in = 2'd0;
         exp_len_in = 3'd0;
         partial_in = 21'd0;
      end
   end

   always_comb begin
      cmd.n_invalid     = n_inv;
      cmd.has_valid     = has_valid;
      cmd.code_point    = vcp;
      cmd.byte_count    = vbytes;
      cmd.utf16_units   = (vcp > BMP_MAX) ? 2'd2 : 2'd1;
      cmd.is_whitespace = ecma_space(vcp);
      push              = accept && ((n_inv != 3'd0) || has_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         exp_len_ff <= 3'd0;
         partial_ff <= 21'd0;
      end else if (accept) begin
         pending_ff <= pending_in;
         exp_len_ff <= exp_len_in;
         partial_ff <= partial_in;
      end
   end

endmodule

>>> rtl/u8dec_queue.sv
// ---------------------------------------------------------------------------
// u8dec_queue
// Small command queue between the sequence tracker and the result expander.
// ---------------------------------------------------------------------------
module u8dec_queue #(
   parameter int Depth = u8dec_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  u8dec_pkg::cmd_type          push_data,
   input  logic                        pop,
   output u8dec_pkg::cmd_type          head,
   output u8dec_pkg::queue_status_type status
);
   import u8dec_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   cmd_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      head         = mem_ff[rd_ptr_ff];
      status.empty = (count_ff == '0);
      status.full  = (count_ff == DepthCnt);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/u8dec_back.sv
// ---------------------------------------------------------------------------
// u8dec_back
// Result expander: turns each queued command into its run of result items.
// ---------------------------------------------------------------------------
module u8dec_back (
   input  logic                        clock,
   input  logic                        reset,
   input  u8dec_pkg::cmd_type          head,
   input  u8dec_pkg::queue_status_type status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output u8dec_pkg::rsp_type          rsp_data
);
   import u8dec_pkg::*;

   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       emit;
   logic [2:0] total;
   logic       last;
   logic       inv_slot;

   always_comb begin
      total    = head.n_invalid + {2'd0, head.has_valid};
      inv_slot = (cnt_ff < head.n_invalid);
      last     = ((cnt_ff + 3'd1) == total);
      emit     = !status.empty && (!rsp_valid_ff || !rsp_stall);
      pop      = emit && last;

      if (inv_slot) begin
         rsp_data_in.code_point    = 21'd0;
         rsp_data_in.is_valid      = 1'b0;
         rsp_data_in.byte_count    = 3'd1;
         rsp_data_in.utf16_units   = 2'd1;
         rsp_data_in.is_whitespace = 1'b0;
      end else begin
         rsp_data_in.code_point    = head.code_point;
         rsp_data_in.is_valid      = 1'b1;
         rsp_data_in.byte_count    = head.byte_count;
         rsp_data_in.utf16_units   = head.utf16_units;
         rsp_data_in.is_whitespace = head.is_whitespace;
      end
      rsp_data_in.last_of_run = last;

      cnt_in = cnt_ff;
      if (emit) begin
         cnt_in = last ? 3'd0 : cnt_ff + 3'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Byte-level check of the UTF-8 validating decoder. Directed byte strings hit
// the lead-byte limits, rejected values, broken and end-of-string flushes;
// then mostly well-formed random sequences, mixed with truncated, rejected
// and noise bytes. A scoreboard decodes every accepted byte on its own and
// compares each result field by field, in order.
// ---------------------------------------------------------------------------
module testbench;
   import u8dec_pkg::*;

   localparam int RANDOM_ITEMS = 345;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 100;
   localparam int PAUSE_AT     = 260;
   localparam int QUIET_TAIL   = 60;
   localparam int STALL_LIMIT  = 1000;
   localparam int MAX_REPORTS  = 100;

   class utf8_scoreboard;
      rsp_type     expected_points[$];
      rsp_type     byte_results[$];
      logic [1:0]  open_count;
      logic [2:0]  open_length;
      logic [20:0] partial;
      int          mismatches;

      function new();
         open_count  = '0;
         open_length = '0;
         partial     = '0;
         mismatches  = 0;
      endfunction

      function int outstanding();
         return expected_points.size();
      endfunction

      function bit is_ecma_blank(logic [20:0] c);
         return c inside {21'h09, 21'h0a, 21'h0b, 21'h0c, 21'h0d, 21'h20, 21'h00a0,
                          21'h1680, [21'h2000:21'h200a], 21'h2028, 21'h2029,
                          21'h202f, 21'h205f, 21'h3000, 21'hfeff};
      endfunction

      // a byte never gives more than four results
      function void emit(logic [20:0] cp, bit ok, logic [2:0] nbytes);
         rsp_type r;
         if (byte_results.size() >= 4) return;
         r.code_point    = ok ? cp : '0;
         r.is_valid      = ok;
         r.byte_count    = ok ? nbytes : 3'd1;
         r.utf16_units   = (ok && cp > BMP_MAX) ? 2'd2 : 2'd1;
         r.is_whitespace = ok && is_ecma_blank(cp);
         r.last_of_run   = 1'b0;
         byte_results.push_back(r);
      endfunction

      function void emit_rejects(int n);
         for (int k = 0; k < n; k++) emit('0, 1'b0, 3'd1);
      endfunction

      function void close_sequence();
         open_count  = '0;
         open_length = '0;
         partial     = '0;
      endfunction

      function void take_lead(logic [7:0] b);
         if (b <= ASCII_HI) begin
            emit({13'd0, b}, 1'b1, 3'd1);
         end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            open_count = 2'd1; open_length = 3'd2; partial = {16'd0, b[4:0]};
         end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            open_count = 2'd1; open_length = 3'd3; partial = {17'd0, b[3:0]};
         end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            open_count = 2'd1; open_length = 3'd4; partial = {18'd0, b[2:0]};
         end else begin
            emit_rejects(1);
         end
      endfunction

      function void note_byte(req_type item);
         logic [7:0]  b;
         logic [2:0]  got;
         logic [20:0] v;
         logic [20:0] floor_cp;
         int          n;
         b = item.in_byte;
         byte_results.delete();
         if (open_count != 0) begin
            if (b[7:6] == 2'b10) begin
               got = {1'b0, open_count} + 3'd1;
               v   = {partial[14:0], b[5:0]};
               if (got >= open_length) begin
                  floor_cp = (open_length == 3'd2) ? MIN_LEN2 :
                             (open_length == 3'd3) ? MIN_LEN3 : MIN_LEN4;
                  if (v < floor_cp || v > CP_MAX || (v >= SURR_LO && v <= SURR_HI))
                     emit_rejects(int'(got));
                  else
                     emit(v, 1'b1, got);
                  close_sequence();
               end else begin
                  open_count = got[1:0];
                  partial    = v;
               end
            end else begin
               // the breaking byte starts over as a lead
               n = int'(open_count);
               close_sequence();
               emit_rejects(n);
               take_lead(b);
            end
         end else begin
            take_lead(b);
         end
         if (item.end_of_string && open_count != 0) begin
            n = int'(open_count);
            close_sequence();
            emit_rejects(n);
         end
         if (byte_results.size() > 0) byte_results[$].last_of_run = 1'b1;
         foreach (byte_results[k]) expected_points.push_back(byte_results[k]);
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $error("unexpected result, code_point %0h", got.code_point);
            return;
         end
         want = expected_points.pop_front();
         compare("code_point", 32'(want.code_point), 32'(got.code_point));
         compare("is_valid", 32'(want.is_valid), 32'(got.is_valid));
         compare("byte_count", 32'(want.byte_count), 32'(got.byte_count));
         compare("utf16_units", 32'(want.utf16_units), 32'(got.utf16_units));
         compare("is_whitespace", 32'(want.is_whitespace), 32'(got.is_whitespace));
         compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   utf8_scoreboard scoreboard = new();
   req_type        byte_stream[$];
   int             bytes_sent = 0;
   bit             quiet = 1'b0;

   utf8_validating_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void put_byte(logic [7:0] b, bit eos);
      req_type item;
      item.in_byte       = b;
      item.end_of_string = eos;
      byte_stream.push_back(item);
   endfunction

   // encodes cp in len bytes whether or not that form is legal, keeps the first keep
   function automatic void add_sequence(logic [20:0] cp, int len, int keep, bit eos);
      logic [7:0] enc [4];
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int k = 0; k < keep; k++) put_byte(enc[k], eos && (k == keep - 1));
   endfunction

   function automatic int length_of(logic [20:0] cp);
      if (cp < MIN_LEN2) return 1;
      if (cp < MIN_LEN3) return 2;
      if (cp < MIN_LEN4) return 3;
      return 4;
   endfunction

   function automatic logic [20:0] pick_point();
      logic [20:0] blanks [8] = '{21'h09, 21'h20, 21'h00a0, 21'h1680, 21'h200a,
                                  21'h2028, 21'h3000, 21'hfeff};
      logic [20:0] edges [9]  = '{21'h7f, 21'h80, 21'h7ff, 21'h800, 21'hd7ff,
                                  21'he000, 21'hffff, 21'h10000, 21'h10ffff};
      logic [20:0] cp;
      case ($urandom_range(0, 5))
         0: cp = 21'($urandom_range(0, 'h7f));
         1: cp = 21'($urandom_range('h80, 'h7ff));
         2: begin
            cp = 21'($urandom_range('h800, 'hffff));
            if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h1000;
         end
         3: cp = 21'($urandom_range('h10000, 'h10ffff));
         4: cp = blanks[$urandom_range(0, 7)];
         default: cp = edges[$urandom_range(0, 8)];
      endcase
      return cp;
   endfunction

   function automatic void build_directed();
      put_byte(8'h00, 1'b0);
      put_byte(8'hff, 1'b0);                      // bad lead
      add_sequence(21'h00040, 3, 3, 1'b0);        // overlong
      add_sequence(21'h0d800, 3, 3, 1'b0);        // surrogate
      add_sequence(21'h1f600, 4, 4, 1'b0);        // two utf-16 units
      add_sequence(21'h02028, 3, 3, 1'b0);        // whitespace
      put_byte(8'hc2, 1'b0);
      put_byte(8'h41, 1'b0);                      // broken, then ascii
      add_sequence(21'h10000, 4, 3, 1'b0);
      put_byte(8'hc0, 1'b0);                      // broken by a bad lead: four results
      add_sequence(21'h02000, 3, 2, 1'b1);        // flushed by end of string
      add_sequence(21'h10000, 4, 3, 1'b0);
      put_byte(8'he2, 1'b1);                      // new lead opened and flushed
   endfunction

   function automatic void build_random();
      int          target;
      int          r;
      int          len;
      logic [20:0] cp;
      target = byte_stream.size() + RANDOM_ITEMS;
      while (byte_stream.size() < target) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            cp = pick_point();
            len = length_of(cp);
            add_sequence(cp, len, len, $urandom_range(0, 9) == 0);
         end else if (r < 80) begin
            case ($urandom_range(0, 2))
               0: begin
                  len = $urandom_range(2, 4);
                  cp = (len == 2) ? 21'($urandom_range(0, 'h7f)) :
                       (len == 3) ? 21'($urandom_range(0, 'h7ff)) :
                                    21'($urandom_range(0, 'hffff));
               end
               1: begin
                  len = 3;
                  cp = 21'($urandom_range('hd800, 'hdfff));
               end
               default: begin
                  len = 4;
                  cp = 21'($urandom_range('h110000, 'h1fffff));
               end
            endcase
            add_sequence(cp, len, len, $urandom_range(0, 9) == 0);
         end else if (r < 90) begin
            do cp = pick_point(); while (length_of(cp) < 2);
            len = length_of(cp);
            add_sequence(cp, len, $urandom_range(1, len - 1), $urandom_range(0, 2) == 0);
         end else begin
            put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) scoreboard.check_result(rsp_data);
   end

   initial begin : receiver
      int stall_left;
      int cyc;
      bit calm;
      bit held;
      stall_left = 0;
      cyc = 0;
      calm = 1'b0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if (!held && bytes_sent >= HOLD_AT) begin
            // long hold-off so the queue fills and req backs up
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("utf8_validating_decoder test failed");
      $finish;
   end

   initial begin : sender
      bit calm;
      build_directed();
      build_random();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < byte_stream.size(); i++) begin
         if (i >= byte_stream.size() - QUIET_TAIL) quiet = 1'b1;
         calm = ((i / 30) % 3 == 2);
         if (i == PAUSE_AT) begin
            // let the decoder drain completely
            req_valid <= 1'b0;
            @(negedge clock);
            while (scoreboard.outstanding() != 0) @(negedge clock);
         end else if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= byte_stream[i];
         @(posedge clock);
         while (req_stall) @(posedge clock);
         scoreboard.note_byte(byte_stream[i]);
         bytes_sent++;
         @(negedge clock);
      end
      req_valid <= 1'b0;
      while (scoreboard.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
         $display("utf8_validating_decoder test passed");
      end else begin
         $display("utf8_validating_decoder test failed");
      end
      $finish;
   end

endmodule
